// ===== rtl/core/hecr_pkg.sv =====
// Shared types, register codes and field constants for the hashed entry cache.
// No dependencies; the interfaces, controller, datapath, top level and testbench import it.
package hecr_pkg;

  // Default table depth and payload field widths
  localparam int ENTRIES_DEFAULT = 4096;
  localparam int KEY_W           = 64;
  localparam int HASH_BITS       = 4;
  localparam int HASH_STEPS      = KEY_W / HASH_BITS;
  localparam int HASH_CNT_W      = $clog2(HASH_STEPS + 1);
  localparam int PAYLOAD_W       = 48;
  localparam int INFO_W          = 20;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [7:0]         ply_t;
  typedef logic [15:0]        move_t;
  typedef logic signed [15:0] score_t;
  typedef logic [7:0]         depth_t;
  typedef logic [1:0]         bound_t;
  typedef logic [7:0]         gen_t;
  typedef logic [14:0]        thr_t;
  typedef logic               cfg_index_t;
  typedef logic [14:0]        cfg_data_t;

  // Operation codes
  localparam logic MODE_PROBE = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  // Bound kinds
  localparam bound_t BOUND_NONE  = 2'd0;
  localparam bound_t BOUND_LOWER = 2'd1;
  localparam bound_t BOUND_UPPER = 2'd2;
  localparam bound_t BOUND_EXACT = 2'd3;

  // Configuration register indexes
  localparam cfg_index_t CFG_MATE_THRESHOLD     = 1'b0;
  localparam cfg_index_t CFG_CURRENT_GENERATION = 1'b1;

  // Configuration reset values
  localparam thr_t MATE_THRESHOLD_RESET     = 15'd30000;
  localparam gen_t CURRENT_GENERATION_RESET = 8'd0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic read_en;
    logic read_from_input;
    logic hash_step;
    logic clear_step;
    logic commit;
  } hecr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hash_done;
    logic clear_done;
    logic out_free;
  } hecr_status_t;

  function automatic logic is_pow2(input int n);
    return (n > 0) && ((n & (n - 1)) == 0);
  endfunction

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/core/hecr_req_if.sv =====
// Request channel: valid/ready handshake with one probe or store item.
// Depends on hecr_pkg for field types.
interface hecr_req_if;
  import hecr_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  key_t   key;
  ply_t   ply;
  move_t  move_code;
  score_t score_in;
  depth_t depth_in;
  score_t eval_in;
  bound_t bound_in;
  logic   pv_flag_in;

  modport source (
    output valid, mode, key, ply, move_code, score_in, depth_in, eval_in, bound_in,
           pv_flag_in,
    input  ready
  );

  modport sink (
    input  valid, mode, key, ply, move_code, score_in, depth_in, eval_in, bound_in,
           pv_flag_in,
    output ready
  );
endinterface

// ===== rtl/core/hecr_rsp_if.sv =====
// Response channel: valid/ready handshake with one result per request.
// Depends on hecr_pkg for field types.
interface hecr_rsp_if;
  import hecr_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  logic   written;
  move_t  move_out;
  score_t score_out;
  depth_t depth_out;
  score_t eval_out;
  bound_t bound_out;
  logic   pv_flag_out;
  gen_t   generation_out;

  modport source (
    output valid, hit, written, move_out, score_out, depth_out, eval_out, bound_out,
           pv_flag_out, generation_out,
    input  ready
  );

  modport sink (
    input  valid, hit, written, move_out, score_out, depth_out, eval_out, bound_out,
           pv_flag_out, generation_out,
    output ready
  );
endinterface

// ===== rtl/core/hecr_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on hecr_pkg for field types.
interface hecr_cfg_if;
  import hecr_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hecr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hecr_ctrl.sv =====
// Sequencing controller: clearing pass, index hashing, table read, evaluate.
// Depends on hecr_pkg for command and status structs.
module hecr_ctrl #(
  parameter int ENTRIES = hecr_pkg::ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  hecr_pkg::hecr_status_t status,
  output hecr_pkg::hecr_cmd_t    cmd
);
  import hecr_pkg::*;

  localparam logic FAST_INDEX = is_pow2(ENTRIES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          if (FAST_INDEX) begin
            cmd.read_en         = 1'b1;
            cmd.read_from_input = 1'b1;
            state_next          = S_EVAL;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (status.hash_done) begin
          state_next = S_READ;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        // hold here while the previous result still waits
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/hecr_dp.sv =====
// Datapath: item and config registers, index unit, entry memories, replacement
// decision, mate score adjustment and the result register. Uses hecr_pkg, hecr_ram.
module hecr_dp #(
  parameter int ENTRIES = hecr_pkg::ENTRIES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hecr_pkg::hecr_cmd_t    cmd,
  output hecr_pkg::hecr_status_t status,
  // request payload
  input  logic                   mode,
  input  hecr_pkg::key_t         key,
  input  hecr_pkg::ply_t         ply,
  input  hecr_pkg::move_t        move_code,
  input  hecr_pkg::score_t       score_in,
  input  hecr_pkg::depth_t       depth_in,
  input  hecr_pkg::score_t       eval_in,
  input  hecr_pkg::bound_t       bound_in,
  input  logic                   pv_flag_in,
  // configuration writes
  input  logic                   cfg_we,
  input  hecr_pkg::cfg_index_t   cfg_index,
  input  hecr_pkg::cfg_data_t    cfg_data,
  // result register
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   hit,
  output logic                   written,
  output hecr_pkg::move_t        move_out,
  output hecr_pkg::score_t       score_out,
  output hecr_pkg::depth_t       depth_out,
  output hecr_pkg::score_t       eval_out,
  output hecr_pkg::bound_t       bound_out,
  output logic                   pv_flag_out,
  output hecr_pkg::gen_t         generation_out
);
  import hecr_pkg::*;

  localparam int   IDX_W      = idx_width(ENTRIES);
  localparam logic FAST_INDEX = is_pow2(ENTRIES);

  // Shift a mate score by ply away from zero when storing, toward zero on read back
  function automatic score_t mate_adj(input score_t s, input ply_t p, input thr_t thr,
                                      input logic storing);
    logic signed [17:0] sx;
    logic signed [17:0] px;
    logic signed [17:0] tx;
    logic signed [17:0] sum;
    sx = 18'(s);
    px = signed'({10'd0, p});
    tx = signed'({3'd0, thr});
    priority if (sx >= tx) begin
      sum = storing ? sx + px : sx - px;
    end else if (sx <= -tx) begin
      sum = storing ? sx - px : sx + px;
    end else begin
      sum = sx;
    end
    priority if (sum > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return sum[15:0];
    end
  endfunction

  // Configuration registers
  thr_t mate_threshold;
  gen_t current_generation;

  always_ff @(posedge clk) begin
    if (rst) begin
      mate_threshold     <= MATE_THRESHOLD_RESET;
      current_generation <= CURRENT_GENERATION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MATE_THRESHOLD:     mate_threshold     <= cfg_data;
        CFG_CURRENT_GENERATION: current_generation <= cfg_data[7:0];
        default:                ;
      endcase
    end
  end

  // Item register
  logic   mode_q;
  key_t   key_q;
  ply_t   ply_q;
  move_t  move_q;
  score_t score_q;
  depth_t depth_q;
  score_t eval_q;
  bound_t bound_q;
  logic   pv_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q  <= mode;
      key_q   <= key;
      ply_q   <= ply;
      move_q  <= move_code;
      score_q <= score_in;
      depth_q <= depth_in;
      eval_q  <= eval_in;
      bound_q <= bound_in;
      pv_q    <= pv_flag_in;
    end
  end

  // Index unit: key mod ENTRIES
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] rd_addr;

  generate
    if (FAST_INDEX) begin : g_mask
      logic [IDX_W-1:0] in_idx;

      // take the low key bits; a one-entry table always maps to zero
      assign in_idx           = key[IDX_W-1:0] & IDX_W'(ENTRIES - 1);
      assign rd_addr          = cmd.read_from_input ? in_idx : idx_q;
      assign status.hash_done = 1'b1;

      always_ff @(posedge clk) begin
        if (cmd.load_item) begin
          idx_q <= in_idx;
        end
      end
    end else begin : g_serial
      logic [KEY_W-1:0]      shreg;
      logic [HASH_CNT_W-1:0] cnt;
      logic [IDX_W-1:0]      rem_next;

      // fold HASH_BITS key bits per step into the remainder, MSB first
      always_comb begin
        logic [IDX_W:0] t;
        t = {1'b0, idx_q};
        for (int b = 0; b < HASH_BITS; b++) begin
          t = {t[IDX_W-1:0], shreg[KEY_W-1-b]};
          if (t >= (IDX_W+1)'(ENTRIES)) begin
            t = t - (IDX_W+1)'(ENTRIES);
          end
        end
        rem_next = t[IDX_W-1:0];
      end

      assign rd_addr          = idx_q;
      assign status.hash_done = (cnt == HASH_CNT_W'(HASH_STEPS));

      always_ff @(posedge clk) begin
        if (cmd.load_item) begin
          idx_q <= '0;
          shreg <= key;
        end else if (cmd.hash_step) begin
          idx_q <= rem_next;
          shreg <= {shreg[KEY_W-HASH_BITS-1:0], HASH_BITS'(0)};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (cmd.load_item) begin
          cnt <= '0;
        end else if (cmd.hash_step) begin
          cnt <= cnt + HASH_CNT_W'(1);
        end
      end
    end
  endgenerate

  // Clearing pass over the info memory after reset
  logic [IDX_W-1:0] clr_addr;

  assign status.clear_done = (clr_addr == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !status.clear_done) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Entry memories
  key_t                 key_rd;
  logic [PAYLOAD_W-1:0] pay_rd;
  logic [INFO_W-1:0]    info_rd;
  logic [PAYLOAD_W-1:0] pay_wr;
  logic [INFO_W-1:0]    info_wr;
  logic                 entry_we;
  logic                 info_we;
  logic [IDX_W-1:0]     info_waddr;
  logic [INFO_W-1:0]    info_wdata;

  assign info_we    = cmd.clear_step || entry_we;
  assign info_waddr = cmd.clear_step ? clr_addr : idx_q;
  assign info_wdata = cmd.clear_step ? '0 : info_wr;

  hecr_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_keys (
    .clk   (clk),
    .we    (entry_we),
    .waddr (idx_q),
    .wdata (key_q),
    .re    (cmd.read_en),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  hecr_ram #(.WIDTH(PAYLOAD_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_payload (
    .clk   (clk),
    .we    (entry_we),
    .waddr (idx_q),
    .wdata (pay_wr),
    .re    (cmd.read_en),
    .raddr (rd_addr),
    .rdata (pay_rd)
  );

  hecr_ram #(.WIDTH(INFO_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_info (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .re    (cmd.read_en),
    .raddr (rd_addr),
    .rdata (info_rd)
  );

  // Unpack the stored entry
  logic   e_valid;
  bound_t e_bound;
  gen_t   e_gen;
  depth_t e_depth;
  logic   e_pv;
  move_t  e_move;
  score_t e_score;
  score_t e_eval;

  assign e_valid = info_rd[0];
  assign e_bound = info_rd[2:1];
  assign e_gen   = info_rd[10:3];
  assign e_depth = info_rd[18:11];
  assign e_pv    = info_rd[19];
  assign e_move  = pay_rd[15:0];
  assign e_score = pay_rd[31:16];
  assign e_eval  = pay_rd[47:32];

  // Replacement decision
  logic replace;

  always_comb begin
    priority if (!e_valid) begin
      replace = 1'b1;
    end else if (e_move == '0 && move_q != '0) begin
      replace = 1'b1;
    end else if (e_move != '0 && move_q == '0) begin
      replace = 1'b0;
    end else if (e_gen != current_generation) begin
      replace = 1'b1;
    end else if (depth_q > e_depth) begin
      replace = 1'b1;
    end else if (depth_q == e_depth &&
                 ((bound_q == BOUND_EXACT && e_bound != BOUND_EXACT) ||
                  (bound_q != BOUND_UPPER && e_bound == BOUND_UPPER))) begin
      replace = 1'b1;
    end else begin
      replace = 1'b0;
    end
  end

  assign entry_we = cmd.commit && (mode_q == MODE_STORE) && replace;
  assign pay_wr   = {eval_q, mate_adj(score_q, ply_q, mate_threshold, 1'b1), move_q};
  assign info_wr  = {pv_q, depth_q, current_generation, bound_q, 1'b1};

  // Probe lookup
  logic probe_hit;

  assign probe_hit = (mode_q == MODE_PROBE) && e_valid && (key_rd == key_q);

  // Result register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit            <= probe_hit;
      written        <= (mode_q == MODE_STORE) && replace;
      move_out       <= probe_hit ? e_move : '0;
      score_out      <= probe_hit ? mate_adj(e_score, ply_q, mate_threshold, 1'b0) : '0;
      depth_out      <= probe_hit ? e_depth : '0;
      eval_out       <= probe_hit ? e_eval : '0;
      bound_out      <= probe_hit ? e_bound : BOUND_NONE;
      pv_flag_out    <= probe_hit && e_pv;
      generation_out <= probe_hit ? e_gen : '0;
    end
  end

endmodule

// ===== rtl/core/hashed_entry_cache_with_replacement.sv =====
// Top level of the hashed entry cache: direct-mapped table with move, generation,
// depth and bound replacement. Uses hecr_pkg, the channel interfaces, hecr_ctrl, hecr_dp.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+----------------------------------------------
//   req     | in  | valid / ready | mode, key, ply, move_code, score_in, depth_in,
//           |     |               | eval_in, bound_in, pv_flag_in
//   rsp     | out | valid / ready | hit, written, move_out, score_out, depth_out,
//           |     |               | eval_out, bound_out, pv_flag_out, generation_out
//   cfg     | in  | valid / ready | index, data (always ready)
//
// A power-of-two ENTRIES accepts an item with the table read, then evaluates and
// writes back before the next item is taken. Other depths add a serial modulo
// unit of HASH_BITS bits per cycle and a table read state before evaluate.
// After reset a clearing pass walks every entry of the info memory with req.ready low.
// A result waits in the output register; the next item is taken and held at
// evaluate until the register frees.
module hashed_entry_cache_with_replacement #(
  parameter int ENTRIES = hecr_pkg::ENTRIES_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  hecr_req_if.sink    req,
  hecr_rsp_if.source  rsp,
  hecr_cfg_if.sink    cfg
);
  import hecr_pkg::*;

  hecr_cmd_t    cmd;
  hecr_status_t status;

  // Configuration writes are always accepted and land in the registers at the next clock edge
  assign cfg.ready = 1'b1;

  hecr_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hecr_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .mode           (req.mode),
    .key            (req.key),
    .ply            (req.ply),
    .move_code      (req.move_code),
    .score_in       (req.score_in),
    .depth_in       (req.depth_in),
    .eval_in        (req.eval_in),
    .bound_in       (req.bound_in),
    .pv_flag_in     (req.pv_flag_in),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .hit            (rsp.hit),
    .written        (rsp.written),
    .move_out       (rsp.move_out),
    .score_out      (rsp.score_out),
    .depth_out      (rsp.depth_out),
    .eval_out       (rsp.eval_out),
    .bound_out      (rsp.bound_out),
    .pv_flag_out    (rsp.pv_flag_out),
    .generation_out (rsp.generation_out)
  );

endmodule

// ===== tb/hashed_entry_cache_with_replacement_tb.sv =====
// Self-checking testbench for the hashed entry cache: directed and random
// probe/store traffic against a shadow table. Uses hecr_pkg and the channel interfaces.
`timescale 1ns / 100ps

module hashed_entry_cache_with_replacement_tb;
  import hecr_pkg::*;

  localparam int NUM_SLOTS      = ENTRIES_DEFAULT;
  localparam int POOL_SLOTS     = 12;
  localparam int KEYS_PER_SLOT  = 4;
  localparam int POOL_KEYS      = POOL_SLOTS * KEYS_PER_SLOT;
  localparam int IDLE_LIMIT     = 20000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int REPORT_LIMIT   = 10;

  // One probe or store item as offered on the request channel
  typedef struct packed {
    logic   mode;
    key_t   key;
    ply_t   ply;
    move_t  move;
    score_t score;
    depth_t depth;
    score_t eval;
    bound_t bound;
    logic   pv;
  } cache_op_t;

  // One result as seen on the response channel
  typedef struct packed {
    logic   hit;
    logic   written;
    move_t  move;
    score_t score;
    depth_t depth;
    score_t eval;
    bound_t bound;
    logic   pv;
    gen_t   gen;
  } lookup_result_t;

  // Shadow copy of one table slot
  typedef struct packed {
    logic   valid;
    key_t   key;
    move_t  move;
    score_t score;
    score_t eval;
    bound_t bound;
    gen_t   gen;
    depth_t depth;
    logic   pv;
  } shadow_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hecr_req_if req_ch ();
  hecr_rsp_if rsp_ch ();
  hecr_cfg_if cfg_ch ();

  hashed_entry_cache_with_replacement DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow state and configuration
  shadow_slot_t   shadow_slots [NUM_SLOTS];
  thr_t           mate_thr = MATE_THRESHOLD_RESET;
  gen_t           cur_generation = CURRENT_GENERATION_RESET;

  // Stimulus bookkeeping
  cache_op_t      pending_ops [$];
  lookup_result_t expected_lookups [$];
  bit             slot_used [NUM_SLOTS];
  key_t           pool_key [POOL_KEYS];
  int             err_cnt = 0;
  int             idle_cnt = 0;
  int             holdoff_req = 0;
  int             holdoff_seen = 0;
  int             holdoff_left = 0;
  int             burst_left = 0;
  int             gap_left = 0;
  logic [15:0]    stall_pat = 16'hFFFF;
  logic [7:0]     stall_step = 8'd0;
  cache_op_t      drv_op;
  cache_op_t      seen_op;
  lookup_result_t seen_rsp;
  lookup_result_t want_rsp;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift a mate score by ply toward (dir -1) or away from (dir +1) zero, saturated
  function automatic score_t mate_shift(input score_t s, input int ply, input int dir);
    int v;
    int thr;
    v   = s;
    thr = mate_thr;
    if (v >= thr) v = v + dir * ply;
    else if (v <= -thr) v = v - dir * ply;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return score_t'(v);
  endfunction

  // Apply one item to the shadow table and return the result it should produce
  function automatic lookup_result_t predict_lookup(input cache_op_t op);
    lookup_result_t r;
    shadow_slot_t   s;
    int             idx;
    logic           wr;
    r   = '0;
    idx = int'(op.key % NUM_SLOTS);
    s   = shadow_slots[idx];
    if (op.mode == MODE_PROBE) begin
      if (s.valid && s.key == op.key) begin
        r.hit   = 1'b1;
        r.move  = s.move;
        r.score = mate_shift(s.score, int'(op.ply), -1);
        r.depth = s.depth;
        r.eval  = s.eval;
        r.bound = s.bound;
        r.pv    = s.pv;
        r.gen   = s.gen;
      end
      return r;
    end
    // Replacement priority: empty, gain a move, keep a move, age, depth, bound
    if (!s.valid) wr = 1'b1;
    else if (s.move == '0 && op.move != '0) wr = 1'b1;
    else if (s.move != '0 && op.move == '0) wr = 1'b0;
    else if (s.gen != cur_generation) wr = 1'b1;
    else if (op.depth > s.depth) wr = 1'b1;
    else if (op.depth == s.depth &&
             ((op.bound == BOUND_EXACT && s.bound != BOUND_EXACT) ||
              (op.bound != BOUND_UPPER && s.bound == BOUND_UPPER))) wr = 1'b1;
    else wr = 1'b0;
    if (wr) begin
      s.valid = 1'b1;
      s.key   = op.key;
      s.move  = op.move;
      s.score = mate_shift(op.score, int'(op.ply), 1);
      s.eval  = op.eval;
      s.bound = op.bound;
      s.gen   = cur_generation;
      s.depth = op.depth;
      s.pv    = op.pv;
      shadow_slots[idx] = s;
      r.written = 1'b1;
    end
    return r;
  endfunction

  // Queue one item; the first touch of any slot is always a store
  task automatic add_op(input logic mode, input key_t key, input ply_t ply, input move_t move,
                        input score_t score, input depth_t depth, input score_t eval,
                        input bound_t bound, input logic pv);
    cache_op_t op;
    int        idx;
    idx = int'(key % NUM_SLOTS);
    op  = '{mode, key, ply, move, score, depth, eval, bound, pv};
    if (op.mode == MODE_PROBE && !slot_used[idx]) op.mode = MODE_STORE;
    if (op.mode == MODE_STORE) slot_used[idx] = 1'b1;
    pending_ops.push_back(op);
  endtask

  // Scores biased toward the mate boundary and the 16-bit extremes
  function automatic score_t pick_score();
    int v;
    int d;
    d = $urandom_range(0, 6);
    case ($urandom_range(0, 4))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = int'(mate_thr) + d - 3;
      2: v = -int'(mate_thr) + d - 3;
      3: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768 + ($urandom_range(0, 1));
      default: v = int'($urandom_range(0, 400)) - 200;
    endcase
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return score_t'(v);
  endfunction

  // Random traffic, mostly on a small pool of colliding keys
  task automatic add_random_ops(input int count);
    key_t   key;
    ply_t   ply;
    move_t  move;
    depth_t depth;
    int     n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) != 0) key = pool_key[$urandom_range(0, POOL_KEYS - 1)];
      else key = {$urandom, $urandom};
      ply   = ($urandom_range(0, 2) == 0) ? ply_t'($urandom_range(0, 3)) : ply_t'($urandom);
      move  = ($urandom_range(0, 3) == 0) ? move_t'(0) : move_t'($urandom);
      depth = ($urandom_range(0, 3) != 0) ? depth_t'($urandom_range(0, 7)) : depth_t'($urandom);
      add_op(($urandom_range(0, 1) != 0) ? MODE_STORE : MODE_PROBE, key, ply, move,
             pick_score(), depth, score_t'($urandom), bound_t'($urandom_range(0, 3)),
             logic'($urandom_range(0, 1)));
    end
  endtask

  // Write one register and wait for the transfer
  task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every queued item has been sent and answered
  task automatic wait_drained();
    while (pending_ops.size() != 0 || req_ch.valid || expected_lookups.size() != 0)
      @(posedge clk);
  endtask

  // Request driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left != 0) begin
        req_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        drv_op = pending_ops.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= drv_op.mode;
        req_ch.key        <= drv_op.key;
        req_ch.ply        <= drv_op.ply;
        req_ch.move_code  <= drv_op.move;
        req_ch.score_in   <= drv_op.score;
        req_ch.depth_in   <= drv_op.depth;
        req_ch.eval_in    <= drv_op.eval;
        req_ch.bound_in   <= drv_op.bound;
        req_ch.pv_flag_in <= drv_op.pv;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response sink: stall pattern redrawn whenever stall_step[5:0] wraps to zero, plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_step <= stall_step + 8'd1;
      if (stall_step[5:0] == 6'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= 16'hFFFF;
          1: stall_pat <= 16'($urandom);
          2: stall_pat <= 16'($urandom) & 16'($urandom);
          default: stall_pat <= 16'($urandom) | 16'($urandom);
        endcase
      end
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen <= holdoff_req;
        holdoff_left <= HOLDOFF_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= stall_pat[stall_step[3:0]];
      end
    end
  end

  // Monitor: track config, predict on request transfer, check on response transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MATE_THRESHOLD:     mate_thr = thr_t'(cfg_ch.data);
          CFG_CURRENT_GENERATION: cur_generation = cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        seen_op = '{req_ch.mode, req_ch.key, req_ch.ply, req_ch.move_code, req_ch.score_in,
                    req_ch.depth_in, req_ch.eval_in, req_ch.bound_in, req_ch.pv_flag_in};
        expected_lookups.push_back(predict_lookup(seen_op));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_rsp = '{rsp_ch.hit, rsp_ch.written, rsp_ch.move_out, rsp_ch.score_out,
                     rsp_ch.depth_out, rsp_ch.eval_out, rsp_ch.bound_out, rsp_ch.pv_flag_out,
                     rsp_ch.generation_out};
        if (expected_lookups.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_LIMIT)
            $display("%0t: result with nothing outstanding: hit=%0d written=%0d",
                     $realtime, seen_rsp.hit, seen_rsp.written);
        end else begin
          want_rsp = expected_lookups.pop_front();
          if (seen_rsp !== want_rsp) begin
            err_cnt++;
            if (err_cnt <= REPORT_LIMIT) begin
              $display("%0t: mismatch expected hit=%0d wr=%0d mv=%h sc=%0d dp=%0d ev=%0d bd=%0d pv=%0d gen=%0d",
                       $realtime, want_rsp.hit, want_rsp.written, want_rsp.move, want_rsp.score,
                       want_rsp.depth, want_rsp.eval, want_rsp.bound, want_rsp.pv, want_rsp.gen);
              $display("%0t:          actual   hit=%0d wr=%0d mv=%h sc=%0d dp=%0d ev=%0d bd=%0d pv=%0d gen=%0d",
                       $realtime, seen_rsp.hit, seen_rsp.written, seen_rsp.move, seen_rsp.score,
                       seen_rsp.depth, seen_rsp.eval, seen_rsp.bound, seen_rsp.pv, seen_rsp.gen);
            end
          end
        end
      end
      // Watchdog on cycles without any transfer
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
          $display("%0t: watchdog expired, %0d results outstanding",
                   $realtime, expected_lookups.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    thr_t   phase_thr [5];
    gen_t   phase_gen [5];
    key_t   key_a;
    key_t   key_a2;
    key_t   key_b;
    key_t   key_b2;
    int     i;
    int     k;
    int     ph;
    logic [11:0] slot;

    // Known values on every block input from time zero
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_PROBE;
    req_ch.key        = '0;
    req_ch.ply        = '0;
    req_ch.move_code  = '0;
    req_ch.score_in   = '0;
    req_ch.depth_in   = '0;
    req_ch.eval_in    = '0;
    req_ch.bound_in   = BOUND_NONE;
    req_ch.pv_flag_in = 1'b0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_MATE_THRESHOLD;
    cfg_ch.data       = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      shadow_slots[i] = '0;
      slot_used[i]    = 1'b0;
    end

    // Key pool: a few slots, several distinct keys per slot
    for (i = 0; i < POOL_SLOTS; i++) begin
      slot = (i == 0) ? 12'h000 : (i == 1) ? 12'hFFF : 12'($urandom);
      for (k = 0; k < KEYS_PER_SLOT; k++)
        pool_key[i * KEYS_PER_SLOT + k] = {$urandom, 20'($urandom), slot};
    end

    key_a  = 64'hFFFF_FFFF_FFFF_F000;
    key_a2 = 64'h0000_0000_0000_0000;
    key_b  = 64'h8000_0000_0000_0FFF;
    key_b2 = 64'h7FFF_FFFF_FFFF_FFFF;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty slot, key mismatch, move rules, depth and bound ties
    add_op(MODE_STORE, key_a,  8'd5,   16'h0000, 100,    8'd3,   -32768, BOUND_NONE,  1'b0);
    add_op(MODE_PROBE, key_a,  8'd0,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_PROBE, key_a2, 8'd0,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_a2, 8'd0,   16'h0000, -5,     8'd3,   0,      BOUND_UPPER, 1'b0);
    add_op(MODE_STORE, key_a2, 8'd0,   16'h0000, -5,     8'd3,   1,      BOUND_EXACT, 1'b1);
    add_op(MODE_STORE, key_a,  8'd0,   16'h0000, 7,      8'd2,   0,      BOUND_EXACT, 1'b0);
    add_op(MODE_STORE, key_a,  8'd0,   16'h1234, 77,     8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_a2, 8'd0,   16'h0000, 0,      8'd255, 0,      BOUND_EXACT, 1'b0);
    add_op(MODE_PROBE, key_a,  8'd9,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    // Mate scores at the 16-bit extremes, saturating both ways
    add_op(MODE_STORE, key_a,  8'd255, 16'hFFFF, 32767,  8'd255, 32767,  BOUND_EXACT, 1'b1);
    add_op(MODE_PROBE, key_a,  8'd0,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_PROBE, key_a,  8'd255, 16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_b,  8'd100, 16'h8000, -32768, 8'd10,  0,      BOUND_LOWER, 1'b1);
    add_op(MODE_PROBE, key_b,  8'd100, 16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_b2, 8'd7,   16'h0005, -30000, 8'd11,  -1,     BOUND_UPPER, 1'b0);
    add_op(MODE_PROBE, key_b2, 8'd0,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_PROBE, key_b2, 8'd255, 16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_b2, 8'd3,   16'h0006, 29999,  8'd11,  2,      BOUND_LOWER, 1'b0);
    add_op(MODE_PROBE, key_b2, 8'd50,  16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_op(MODE_STORE, key_b2, 8'd3,   16'h0006, 30000,  8'd11,  2,      BOUND_LOWER, 1'b1);
    add_op(MODE_PROBE, key_b,  8'd0,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    wait_drained();

    // Older generation gives way to a shallower store
    write_reg(CFG_CURRENT_GENERATION, {7'($urandom), 8'd255});
    add_op(MODE_STORE, key_a,  8'd0,   16'h0007, -31000, 8'd0,   -7,     BOUND_UPPER, 1'b0);
    add_op(MODE_PROBE, key_a,  8'd1,   16'h0000, 0,      8'd0,   0,      BOUND_NONE,  1'b0);
    add_random_ops(310);

    // Random phases over several register settings, extremes included
    phase_thr = '{15'd0, 15'h7FFF, thr_t'($urandom), 15'd100, 15'd30000};
    phase_gen = '{8'd1, 8'd0, gen_t'($urandom), 8'd2, 8'd2};
    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_reg(CFG_MATE_THRESHOLD, phase_thr[ph]);
      write_reg(CFG_CURRENT_GENERATION, {7'($urandom), phase_gen[ph]});
      add_random_ops(310);
      // Back up the block with a long response hold-off
      if (ph == 0) holdoff_req++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_lookups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hecr_pkg.sv
rtl/core/hecr_req_if.sv
rtl/core/hecr_rsp_if.sv
rtl/core/hecr_cfg_if.sv
rtl/core/hecr_ram.sv
rtl/core/hecr_ctrl.sv
rtl/core/hecr_dp.sv
rtl/core/hashed_entry_cache_with_replacement.sv
tb/hashed_entry_cache_with_replacement_tb.sv
